// ----- sv/fss_pkg.sv -----
// package for the fft size smooth search block
// holds the sequencer state type, search constants and the odd prime inverses
// no dependencies
package fss_pkg;

	localparam int SIZE_BITS_DEF = 20;
	localparam int EXT_BITS      = 16;
	localparam int WIDTH_DIVISOR = 20;
	localparam int WIDTH_SHIFT   = 2;
	localparam int MIN_WIDTH     = 3;
	localparam int LEFTOVER_A    = 11;
	localparam int LEFTOVER_B    = 13;

	localparam longint unsigned WIDTH_ODD = 64'd5;
	localparam longint unsigned PRIME_3   = 64'd3;
	localparam longint unsigned PRIME_5   = 64'd5;
	localparam longint unsigned PRIME_7   = 64'd7;

	// inverses of the odd primes modulo 2^64
	localparam longint unsigned INV_3 = 64'hAAAA_AAAA_AAAA_AAAB;
	localparam longint unsigned INV_5 = 64'hCCCC_CCCC_CCCC_CCCD;
	localparam longint unsigned INV_7 = 64'h6DB6_DB6D_B6DB_6DB7;

	typedef logic [1:0] prime_idx_t;

	localparam prime_idx_t PRIME_IDX_FIRST = 2'd0;
	localparam prime_idx_t PRIME_IDX_MID   = 2'd1;
	localparam prime_idx_t PRIME_IDX_LAST  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIDTH,
		ST_CAND,
		ST_TWO,
		ST_TRY,
		ST_EVAL,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

// ----- sv/fft_size_smooth_search.sv -----
// fft size smooth search top level
// sequencer around one shared multiplier: reciprocal for the width, inverses for 3, 5 and 7
// depends on fss_pkg
//
// Takes a transform size and returns the smallest extension e from 0 up to the
// search width W = max(3, size / 20) such that size + e has only factors 2, 3, 5
// and 7 (at least one of them), or is 11 or 13, alone or times such a number.
// found is 0 and extension equals W when no such length lies within the width.
// One word is handled at a time and in_stall is high while the search runs. The
// width takes one multiply on the shared multiplier. Each candidate then passes
// through ST_CAND, ST_TWO and ST_TRY to ST_EVAL, and a rejected one on to ST_NEXT.
// ST_TWO shifts out one factor of two at a time, and ST_TRY does one multiply by a
// modular inverse for every trial by 3, 5 and 7: one failing trial per prime plus
// one more per factor found. A zero candidate goes from ST_CAND straight to
// ST_NEXT. A result word may wait at the output while the next word is taken in.
module fft_size_smooth_search
	import fss_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SIZE_BITS-1:0] size,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [EXT_BITS-1:0]  extension
);

	localparam int DB = SIZE_BITS + 1;
	localparam int PB = 2 * DB;
	localparam int WB = (SIZE_BITS - 4 > 2) ? SIZE_BITS - 4 : 2;

	localparam longint unsigned DB_MASK = (64'd1 << DB) - 64'd1;

	localparam logic [DB-1:0] WIDTH_RECIP = DB'((DB_MASK + WIDTH_ODD) / WIDTH_ODD);
	localparam logic [DB-1:0] MUL_INV_3   = DB'(INV_3);
	localparam logic [DB-1:0] MUL_INV_5   = DB'(INV_5);
	localparam logic [DB-1:0] MUL_INV_7   = DB'(INV_7);
	localparam logic [DB-1:0] DIV_LIM_3   = DB'(DB_MASK / PRIME_3);
	localparam logic [DB-1:0] DIV_LIM_5   = DB'(DB_MASK / PRIME_5);
	localparam logic [DB-1:0] DIV_LIM_7   = DB'(DB_MASK / PRIME_7);

	state_t state_q, state_d;

	logic [SIZE_BITS-1:0] size_q;
	logic [WB-1:0]        w_q;
	logic [WB-1:0]        e_q;
	logic [DB-1:0]        v_q;
	logic                 had_q;
	prime_idx_t           pidx_q;
	logic                 res_found_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [EXT_BITS-1:0]  ext_q;

	logic [DB-1:0]        inv;
	logic [DB-1:0]        lim;
	logic [DB-1:0]        mul_a;
	logic [DB-1:0]        mul_b;
	logic [PB-1:0]        prod;
	logic [DB-1:0]        w_quo;
	logic                 divides;
	logic [DB-1:0]        cand;
	logic                 friendly;
	logic                 out_take;

	always_comb begin
		inv = MUL_INV_7;
		lim = DIV_LIM_7;
		unique case (pidx_q)
			PRIME_IDX_FIRST: begin
				inv = MUL_INV_3;
				lim = DIV_LIM_3;
			end
			PRIME_IDX_MID: begin
				inv = MUL_INV_5;
				lim = DIV_LIM_5;
			end
			default: begin
				inv = MUL_INV_7;
				lim = DIV_LIM_7;
			end
		endcase
	end

	// shared multiplier
	assign mul_a   = (state_q == ST_WIDTH) ? DB'(size_q >> WIDTH_SHIFT) : v_q;
	assign mul_b   = (state_q == ST_WIDTH) ? WIDTH_RECIP : inv;
	assign prod    = PB'(mul_a) * PB'(mul_b);
	assign w_quo   = prod[PB-1:DB];
	assign divides = prod[DB-1:0] <= lim;

	assign cand     = DB'(size_q) + DB'(e_q);
	assign friendly = (v_q == DB'(1) && had_q) || v_q == DB'(LEFTOVER_A)
		|| v_q == DB'(LEFTOVER_B);
	assign out_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_WIDTH;
				end
			end
			ST_WIDTH: begin
				state_d = ST_CAND;
			end
			ST_CAND: begin
				state_d = (cand == '0) ? ST_NEXT : ST_TWO;
			end
			ST_TWO: begin
				if (v_q[0]) begin
					state_d = ST_TRY;
				end
			end
			ST_TRY: begin
				if (!divides && pidx_q == PRIME_IDX_LAST) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = friendly ? ST_DONE : ST_NEXT;
			end
			ST_NEXT: begin
				state_d = (e_q == w_q) ? ST_DONE : ST_CAND;
			end
			ST_DONE: begin
				if (out_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				size_q <= size;
			end
			ST_WIDTH: begin
				e_q <= '0;
				if (w_quo < DB'(MIN_WIDTH)) begin
					w_q <= WB'(MIN_WIDTH);
				end else begin
					w_q <= w_quo[WB-1:0];
				end
			end
			ST_CAND: begin
				v_q    <= cand;
				had_q  <= 1'b0;
				pidx_q <= PRIME_IDX_FIRST;
			end
			ST_TWO: begin
				if (!v_q[0]) begin
					v_q   <= v_q >> 1;
					had_q <= 1'b1;
				end
			end
			ST_TRY: begin
				if (divides) begin
					v_q   <= prod[DB-1:0];
					had_q <= 1'b1;
				end else if (pidx_q != PRIME_IDX_LAST) begin
					pidx_q <= pidx_q + prime_idx_t'(1);
				end
			end
			ST_EVAL: begin
				res_found_q <= friendly;
			end
			ST_NEXT: begin
				res_found_q <= 1'b0;
				if (e_q != w_q) begin
					e_q <= e_q + WB'(1);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_take) begin
			found_q <= res_found_q;
			ext_q   <= EXT_BITS'(e_q);
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign extension = ext_q;

endmodule

// ----- tb/tb_fft_size_smooth_search.sv -----
// testbench for fft_size_smooth_search: directed and random sizes with random gaps and stalls
// a small class predicts found and extension per size and checks each result word in order
// depends on fss_pkg and fft_size_smooth_search
`timescale 1ns / 100ps

module tb_fft_size_smooth_search;
	import fss_pkg::*;

	localparam int SB = SIZE_BITS_DEF;
	localparam int RANDOM_WORDS = 555;
	localparam longint unsigned SMOOTH_P [4] = '{2, 3, 5, 7};
	localparam logic [SB-1:0] DIRECTED [25] = '{
		0, 1, 2, 3, 4, 11, 13, 22, 26, 57, 77, 79, 121, 143, 169, 242, 286,
		1001, 1331, 2197, 65535, 524287, 524288, 1048574, 1048575
	};

	typedef struct packed {
		logic                found;
		logic [EXT_BITS-1:0] ext;
	} search_word_t;

	class smooth_ext_board;
		search_word_t ext_due[$];
		int errors;
		int sizes_seen;
		int words_seen;
		int misses;

		function new();
			errors = 0;
			sizes_seen = 0;
			words_seen = 0;
			misses = 0;
		endfunction

		function search_word_t nearest_smooth(logic [SB-1:0] s);
			search_word_t w;
			longint unsigned lim, e, v;
			bit had, ok;
			lim = 64'(s);
			lim = lim / 64'(WIDTH_DIVISOR);
			if (lim < 64'(MIN_WIDTH)) begin
				lim = 64'(MIN_WIDTH);
			end
			w.found = 1'b0;
			w.ext = EXT_BITS'(lim);
			e = 0;
			while (!w.found && e <= lim) begin
				v = longint'(s) + e;
				had = 1'b0;
				ok = 1'b0;
				if (v != 0) begin
					foreach (SMOOTH_P[i]) begin
						while (v % SMOOTH_P[i] == 0) begin
							v = v / SMOOTH_P[i];
							had = 1'b1;
						end
					end
					ok = (v == 1) ? had
						: (v == 64'(LEFTOVER_A) || v == 64'(LEFTOVER_B));
				end
				if (ok) begin
					w.found = 1'b1;
					w.ext = EXT_BITS'(e);
				end
				e++;
			end
			return w;
		endfunction

		function void note_size(logic [SB-1:0] s);
			search_word_t w;
			w = nearest_smooth(s);
			if (!w.found) begin
				misses++;
			end
			sizes_seen++;
			ext_due.push_back(w);
		endfunction

		function void check_word(logic f, logic [EXT_BITS-1:0] x);
			search_word_t w;
			words_seen++;
			if (ext_due.size() == 0) begin
				$error("result word with no size waiting: found %0d extension %0d", f, x);
				errors++;
			end else begin
				w = ext_due.pop_front();
				if (f !== w.found) begin
					$error("found: expected %0d, got %0d", w.found, f);
					errors++;
				end
				if (x !== w.ext) begin
					$error("extension: expected %0d, got %0d", w.ext, x);
					errors++;
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [SB-1:0]       size;
	logic                out_valid;
	logic                out_stall;
	logic                found;
	logic [EXT_BITS-1:0] extension;
	bit                  quiet;

	smooth_ext_board board = new();

	fft_size_smooth_search #(
		.SIZE_BITS(SB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.size(size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.extension(extension)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	initial begin
		#200000000;
		$display("tb_fft_size_smooth_search failed");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_size(input logic [SB-1:0] s);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		size <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			board.note_size(size);
		end
		if (arst_n && out_valid && !out_stall) begin
			board.check_word(found, extension);
		end
	end

	// receiver stalls
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		logic [SB-1:0] s;
		longint unsigned v, f, off;
		int r, k;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		size <= '0;
		quiet = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			send_size(DIRECTED[i]);
		end

		for (k = 0; k < RANDOM_WORDS; k++) begin
			quiet = (k >= 250 && k < 320);
			r = $urandom_range(0, 99);
			if (k == 400) begin
				s = SB'($urandom_range(1, (1 << SB) - 1));
			end else if (r < 50) begin
				s = SB'($urandom_range(0, 255));
			end else if (r < 85) begin
				s = SB'($urandom_range(256, 4095));
			end else if (r < 97) begin
				// just below a friendly length anywhere in range
				v = 1;
				repeat ($urandom_range(4, 30)) begin
					f = SMOOTH_P[$urandom_range(0, 3)];
					if (v * f < (64'd1 << SB)) begin
						v = v * f;
					end
				end
				f = ($urandom_range(0, 1) == 0) ? 64'(LEFTOVER_A) : 64'(LEFTOVER_B);
				if ($urandom_range(0, 2) == 0 && v * f < (64'd1 << SB)) begin
					v = v * f;
				end
				off = 64'($urandom_range(0, 40));
				v = (off > v) ? 0 : v - off;
				s = SB'(v);
			end else begin
				s = SB'($urandom_range(4096, 32767));
			end
			send_size(s);
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		while (board.ext_due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("%0d sizes searched (%0d directed), %0d result words checked",
			board.sizes_seen, $size(DIRECTED), board.words_seen);
		$display("%0d sizes had no friendly length within the width, %0d mismatches",
			board.misses, board.errors);
		if (board.errors == 0) begin
			$display("tb_fft_size_smooth_search passed");
		end else begin
			$display("tb_fft_size_smooth_search failed");
		end
		$finish;
	end

endmodule

// ----- fft_size_smooth_search.f -----
sv/fss_pkg.sv
sv/fft_size_smooth_search.sv
tb/tb_fft_size_smooth_search.sv
